// ----- rtl/core/bcfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfd_pkg
// shared types, constants and the log table of the box-counting dimension unit
// ----------------------------------------------------------------------------
package bcfd_pkg;

  localparam int unsigned SAMPLE_W    = 32;
  localparam int unsigned DIM_W       = 17;
  localparam int unsigned BIN_W       = 3;
  localparam int unsigned BIN_COUNT   = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned WIN_W       = 10;
  localparam int unsigned WIN_RESET   = 256;
  localparam int unsigned SEEN_W      = 16;
  localparam int unsigned MIN_SEEN    = 4;
  localparam int unsigned MIN_SAMPLES = 16;
  localparam int unsigned COARSE_W    = 2;

  // quantiser control and status
  typedef struct packed {
    logic start;
  } bin_ctrl_t;

  typedef struct packed {
    logic             done;
    logic [BIN_W-1:0] bin;
  } bin_stat_t;

  // round(65536 * log4(k)), zero for k of zero
  function automatic logic [DIM_W-1:0] log4_q16(input logic [CNT_W-1:0] k);
    logic [DIM_W-1:0] r;
    unique case (k)
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd51936;
      4'd4:    r = 17'd65536;
      4'd5:    r = 17'd76085;
      4'd6:    r = 17'd84704;
      4'd7:    r = 17'd91991;
      4'd8:    r = 17'd98304;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] count_bins(input logic [BIN_COUNT-1:0] m);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < BIN_COUNT; i++) begin
      c = c + CNT_W'(m[i]);
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/bcfd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfd_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bcfd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bcfd_bin_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfd_bin_unit
// iterative bin quantiser: one subtract, then three restoring division steps
// ----------------------------------------------------------------------------
module bcfd_bin_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  bcfd_pkg::bin_ctrl_t                  ctrl_i,
  input  logic [bcfd_pkg::SAMPLE_W-1:0]        sample_i,
  input  logic [bcfd_pkg::SAMPLE_W-1:0]        min_i,
  input  logic [bcfd_pkg::SAMPLE_W-1:0]        span_i,
  output bcfd_pkg::bin_stat_t                  stat_o
);

  localparam int unsigned SW = bcfd_pkg::SAMPLE_W;

  logic [SW-1:0] rem_q, rem_d;
  logic [1:0]    quo_q, quo_d;
  logic [1:0]    step_q, step_d;
  logic          busy_q, busy_d;
  logic [SW:0]   dbl;
  logic [SW:0]   trial;
  logic          ge;

  // remainder stays at most span, and doubling it fits one extra bit
  assign dbl   = {rem_q, 1'b0};
  assign trial = dbl - {1'b0, span_i};
  assign ge    = dbl >= {1'b0, span_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    busy_d = busy_q;
    if (ctrl_i.start) begin
      rem_d  = sample_i - min_i;
      quo_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? trial[SW-1:0] : dbl[SW-1:0];
      quo_d  = {quo_q[0], ge};
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // a value equal to span comes out as all ones, which is the clamp
  assign stat_o.done = busy_q && (step_q == 2'd2);
  assign stat_o.bin  = {quo_q, ge};

endmodule

// ----- rtl/core/box_count_fractal_dimension_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_count_fractal_dimension_unit
// two-scale box-counting dimension over a sliding window of closing prices
// ----------------------------------------------------------------------------
// Each input word is one closing price. It is stored in a ring of MAX_WINDOW
// samples; once the window (window_length + 1 samples, fewer early on, the
// first sample after reset never counted) holds at least 16 samples and its
// prices are not flat, one word with |log4(n1/n2)| in unsigned Q1.16 is
// produced, where n1 counts the occupied bins of eight equal bins over all
// samples and n2 over every fourth sample. A word with a result is worked in
// two passes: a min/max pass with one ram read per cycle, then a pass that
// bins each sample in the shared bin quantiser, which sets the pace of that
// second pass. The input is not ready while a word is in work.
module box_count_fractal_dimension_unit #(
  parameter int unsigned MAX_WINDOW = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // close_price [31:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // dimension [16:0], zero pad [23:17]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // window_length [9:0]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WINDOW);
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SW = bcfd_pkg::SAMPLE_W;
  localparam int unsigned DW = bcfd_pkg::DIM_W;
  localparam int unsigned NW = bcfd_pkg::SEEN_W + 1;
  localparam int unsigned BC = bcfd_pkg::BIN_COUNT;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_SPAN  = 3'd2;
  localparam logic [2:0] ST_PRIME = 3'd3;
  localparam logic [2:0] ST_BINS  = 3'd4;
  localparam logic [2:0] ST_LOG   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0]                    state_q, state_d;
  logic [bcfd_pkg::WIN_W-1:0]    win_q, win_d;
  logic [AW-1:0]                 wp_q, wp_d;
  logic [bcfd_pkg::SEEN_W-1:0]   seen_q, seen_d;
  logic [CW-1:0]                 n_q, n_d;
  logic [AW-1:0]                 pos0_q, pos0_d;
  logic [AW-1:0]                 addr_q, addr_d;
  logic [CW-1:0]                 iss_q, iss_d;
  logic                          pend_q, pend_d;
  logic [CW-1:0]                 sc_q, sc_d;
  logic [CW-1:0]                 k_q, k_d;
  logic                          first_q, first_d;
  logic [SW-1:0]                 mn_q, mn_d;
  logic [SW-1:0]                 mx_q, mx_d;
  logic [SW-1:0]                 span_q, span_d;
  logic [BC-1:0]                 m1_q, m1_d;
  logic [BC-1:0]                 m2_q, m2_d;
  logic [DW-1:0]                 res_q, res_d;
  logic                          ovalid_q, ovalid_d;
  logic [DW-1:0]                 odata_q, odata_d;

  logic                          in_fire;
  logic [bcfd_pkg::SEEN_W-1:0]   seen_nx;
  logic [bcfd_pkg::SEEN_W-1:0]   idx;
  logic [NW-1:0]                 max_w, w_clamp, w_plus, idx_ext, n_full;
  logic [CW-1:0]                 n_new;
  logic                          go;
  logic [AW-1:0]                 wp_nx;
  logic [CW-1:0]                 wp_ext, pos0_full;
  logic [AW-1:0]                 addr_nx;
  logic [CW-1:0]                 sc_nx;

  logic                          re;
  logic [SW-1:0]                 rdata;
  bcfd_pkg::bin_ctrl_t           bin_ctrl;
  bcfd_pkg::bin_stat_t           bin_stat;
  logic [bcfd_pkg::CNT_W-1:0]    n1, n2;
  logic [DW-1:0]                 la, lb;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // window size for the word being accepted
  assign seen_nx   = (seen_q == '1) ? seen_q : seen_q + 1'b1;
  assign idx       = seen_nx - 1'b1;
  assign max_w     = NW'(MAX_WINDOW - 1);
  assign w_clamp   = (NW'(win_q) > max_w) ? max_w : NW'(win_q);
  assign w_plus    = w_clamp + 1'b1;
  assign idx_ext   = NW'(idx);
  assign n_full    = (idx_ext > w_plus) ? w_plus : idx_ext;
  assign n_new     = n_full[CW-1:0];
  assign go        = (seen_nx >= bcfd_pkg::SEEN_W'(bcfd_pkg::MIN_SEEN)) &&
                     (n_full >= NW'(bcfd_pkg::MIN_SAMPLES));

  assign wp_nx     = (wp_q == AW'(MAX_WINDOW - 1)) ? '0 : wp_q + 1'b1;
  assign wp_ext    = CW'(wp_nx);
  assign pos0_full = (wp_ext >= n_new) ? wp_ext - n_new
                                       : CW'(MAX_WINDOW) - (n_new - wp_ext);
  assign addr_nx   = (addr_q == AW'(MAX_WINDOW - 1)) ? '0 : addr_q + 1'b1;
  assign sc_nx     = sc_q + 1'b1;

  assign n1 = bcfd_pkg::count_bins(m1_q);
  assign n2 = bcfd_pkg::count_bins(m2_q);
  assign la = bcfd_pkg::log4_q16(n1);
  assign lb = bcfd_pkg::log4_q16(n2);

  always_comb begin
    state_d  = state_q;
    win_d    = win_q;
    wp_d     = wp_q;
    seen_d   = seen_q;
    n_d      = n_q;
    pos0_d   = pos0_q;
    addr_d   = addr_q;
    iss_d    = iss_q;
    pend_d   = pend_q;
    sc_d     = sc_q;
    k_d      = k_q;
    first_d  = first_q;
    mn_d     = mn_q;
    mx_d     = mx_q;
    span_d   = span_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    res_d    = res_q;
    odata_d  = odata_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    re       = 1'b0;
    bin_ctrl.start = 1'b0;

    if (cfg_valid_i) begin
      win_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          wp_d   = wp_nx;
          seen_d = seen_nx;
          n_d    = n_new;
          pos0_d = pos0_full[AW-1:0];
          addr_d = pos0_full[AW-1:0];
          iss_d  = '0;
          pend_d = 1'b0;
          mn_d   = '1;
          mx_d   = '0;
          m1_d   = '0;
          m2_d   = '0;
          if (go) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        re     = (iss_q < n_q);
        pend_d = re;
        if (re) begin
          addr_d = addr_nx;
          iss_d  = iss_q + 1'b1;
        end
        if (pend_q) begin
          if (rdata < mn_q) mn_d = rdata;
          if (rdata > mx_q) mx_d = rdata;
        end
        if (!re && !pend_q) begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        span_d = mx_q - mn_q;
        addr_d = pos0_q;
        state_d = (mx_q > mn_q) ? ST_PRIME : ST_IDLE;
      end
      ST_PRIME: begin
        re      = 1'b1;
        addr_d  = addr_nx;
        sc_d    = '0;
        k_d     = '0;
        first_d = 1'b1;
        state_d = ST_BINS;
      end
      ST_BINS: begin
        // the next sample starts as the previous one finishes
        bin_ctrl.start = first_q || (bin_stat.done && (k_q != n_q - 1'b1));
        first_d = 1'b0;
        if (bin_ctrl.start) begin
          sc_d = sc_nx;
          if (sc_nx < n_q) begin
            re     = 1'b1;
            addr_d = addr_nx;
          end
        end
        if (bin_stat.done) begin
          m1_d[bin_stat.bin] = 1'b1;
          if (k_q[bcfd_pkg::COARSE_W-1:0] == '0) begin
            m2_d[bin_stat.bin] = 1'b1;
          end
          k_d = k_q + 1'b1;
          if (k_q == n_q - 1'b1) begin
            state_d = ST_LOG;
          end
        end
      end
      ST_LOG: begin
        res_d   = (la >= lb) ? la - lb : lb - la;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      win_q    <= bcfd_pkg::WIN_W'(bcfd_pkg::WIN_RESET);
      wp_q     <= '0;
      seen_q   <= '0;
      iss_q    <= '0;
      pend_q   <= 1'b0;
      sc_q     <= '0;
      k_q      <= '0;
      first_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      win_q    <= win_d;
      wp_q     <= wp_d;
      seen_q   <= seen_d;
      iss_q    <= iss_d;
      pend_q   <= pend_d;
      sc_q     <= sc_d;
      k_q      <= k_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    pos0_q  <= pos0_d;
    addr_q  <= addr_d;
    mn_q    <= mn_d;
    mx_q    <= mx_d;
    span_q  <= span_d;
    m1_q    <= m1_d;
    m2_q    <= m2_d;
    res_q   <= res_d;
    odata_q <= odata_d;
  end

  bcfd_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (in_fire),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata),
    .re_i    (re),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  bcfd_bin_unit u_bin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (bin_ctrl),
    .sample_i (rdata),
    .min_i    (mn_q),
    .span_i   (span_q),
    .stat_o   (bin_stat)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {7'b0, odata_q};

endmodule

// ----- rtl/core/bcfd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfd_checker
// port-level checks of the box-counting dimension unit
// ----------------------------------------------------------------------------
module bcfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // dimension stays within log4 of eight, pad bits zero
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:17] == 7'd0) &&
                      (m_axis_tdata[16:0] <= 17'd98304))
    else $error("dimension out of range");

  // a new result only comes at the end of a busy spell
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input side was idle");

endmodule

bind box_count_fractal_dimension_unit bcfd_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
